FILE: design/swtm_pkg.sv
// Package for the sorted-window trimmed mean filter.
// Holds the window geometry, fixed-point constants and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package swtm_pkg;

   // Window geometry
   localparam int WINDOW   = 12;
   localparam int IDX_W    = $clog2(WINDOW);
   localparam int SAMPLE_W = 24;

   // Most negative sample, used to pre-fill the sorter so that it ranks below everything
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Last window position and the last value of the insertion count per transaction
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW - 1);
   localparam logic [IDX_W-1:0] LAST_READ = IDX_W'(WINDOW - 2);

   // Accumulator widths of the weighted sum (magnitude up to 36 * 2^23)
   localparam int PART_W = SAMPLE_W + 2;   // sum of three samples
   localparam int PAIR_W = SAMPLE_W + 1;   // sum of two samples
   localparam int MID_W  = SAMPLE_W + 3;   // sum of six samples, and 2*pair + pair
   localparam int ACC_W  = SAMPLE_W + 6;   // full weighted sum
   localparam int MAG_W  = ACC_W - 3;      // magnitude divided by four

   // Division by nine as a multiplication by ceil(2^33 / 9), exact below 2^33
   localparam int               RECIP_SHIFT = 33;
   localparam int               RECIP_W     = 30;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 30'd954437177;
   localparam int               PROD_W      = MAG_W + RECIP_W;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT,
      ST_SUM,
      ST_MERGE,
      ST_TOTAL,
      ST_ABS,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

FILE: design/sorted_window_trimmed_mean.sv
// Sorted-window trimmed mean filter: top level.
// Depends on swtm_pkg for window geometry, fixed-point constants and states.
`timescale 1ns / 1ps

// Usage
// -----
// The req_ channel takes one signed 24-bit sample per transaction. The block
// keeps the twelve most recent samples, ranks them in descending order and
// returns on the rsp_ channel one weighted trimmed mean per transaction:
// (5*(r3+..+r8) + 2*(r1+r10) + (r2+r9)) / 36, truncated toward zero.
// The history sits in a twelve-entry memory with a registered read port. A
// transaction writes the new sample and then reads the eleven other stored
// samples one per cycle into a register insertion sorter. Registered steps of
// summing, taking the magnitude and dividing by 36 follow before rsp_tvalid
// rises. The block works on one sample at a time: req_tready is high only
// while it is idle, so it takes no new sample until the last one's result is
// in the output register. The result waits there, so a new sample is taken
// while rsp_tvalid is still pending; if the receiver stalls for longer, the
// next result holds in the final state until the output register is free.
// Reset clears the history to zero and empties the output register.
module sorted_window_trimmed_mean (
   input  logic                          clock,
   input  logic                          reset,
   // Sample channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [swtm_pkg::SAMPLE_W-1:0] req_tdata,   // [23:0] sample
   // Result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [swtm_pkg::SAMPLE_W-1:0] rsp_tdata    // [23:0] filtered
);

   import swtm_pkg::*;

   // Sequencer
   state_type state_ff, state_in;
   logic      req_accept;
   logic      sort_load;
   logic      sort_insert;
   logic      out_load;
   logic      out_free;

   // History memory with one valid bit per entry (invalid reads as zero)
   logic signed [SAMPLE_W-1:0] hist_mem [WINDOW];
   logic [WINDOW-1:0]          hist_vld_ff;
   logic [IDX_W-1:0]           wr_ptr_ff;
   logic [IDX_W-1:0]           rd_ptr_ff;
   logic [IDX_W-1:0]           rd_addr;
   logic [IDX_W-1:0]           ins_cnt_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       rd_vld_ff;
   logic signed [SAMPLE_W-1:0] ins_value;

   // Insertion sorter, descending
   logic signed [SAMPLE_W-1:0] sort_ff [WINDOW];
   logic signed [SAMPLE_W-1:0] sort_in [WINDOW];
   logic [WINDOW-1:0]          sort_ge;

   // Arithmetic pipeline
   logic signed [PART_W-1:0] part_hi_ff, part_lo_ff;
   logic signed [PAIR_W-1:0] pair_near_ff, pair_far_ff;
   logic signed [MID_W-1:0]  mid_ff, edge_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_abs;
   logic [MAG_W-1:0]         mag_ff;
   logic                     neg_abs_ff, neg_mul_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [SAMPLE_W-1:0]      quot;
   logic [SAMPLE_W-1:0]      result;

   // Output register
   logic                rsp_vld_ff;
   logic [SAMPLE_W-1:0] rsp_data_ff;

   function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] ptr);
      logic [IDX_W-1:0] nxt;
      nxt = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
      return nxt;
   endfunction

   assign out_free = !rsp_vld_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_SORT;
         ST_SORT:  if (ins_cnt_ff == LAST_READ) state_in = ST_SUM;
         ST_SUM:   state_in = ST_MERGE;
         ST_MERGE: state_in = ST_TOTAL;
         ST_TOTAL: state_in = ST_ABS;
         ST_ABS:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      sort_load   = 1'b0;
      sort_insert = 1'b0;
      out_load    = 1'b0;
      rd_addr     = rd_ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            sort_load  = req_tvalid;
            rd_addr    = ptr_next(wr_ptr_ff);
         end
         ST_SORT: sort_insert = 1'b1;
         ST_DONE: out_load = out_free;
         default: ;
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pointers: the new sample replaces the oldest entry, then the rest are read in turn
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         hist_vld_ff <= '0;
      end else if (req_accept) begin
         wr_ptr_ff              <= ptr_next(wr_ptr_ff);
         hist_vld_ff[wr_ptr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ptr_ff  <= ptr_next(ptr_next(wr_ptr_ff));
         ins_cnt_ff <= '0;
      end else if (sort_insert) begin
         rd_ptr_ff  <= ptr_next(rd_ptr_ff);
         ins_cnt_ff <= ins_cnt_ff + 1'b1;
      end
   end

   // History memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         hist_mem[wr_ptr_ff] <= signed'(req_tdata);
      end
      rd_data_ff <= hist_mem[rd_addr];
      rd_vld_ff  <= hist_vld_ff[rd_addr];
   end

   assign ins_value = rd_vld_ff ? rd_data_ff : '0;

   // Insertion of one value into the descending sorted registers
   always_comb begin
      for (int k = 0; k < WINDOW; k++) begin
         sort_ge[k] = (sort_ff[k] >= ins_value);
      end
      sort_in[0] = sort_ge[0] ? sort_ff[0] : ins_value;
      for (int k = 1; k < WINDOW; k++) begin
         if (sort_ge[k]) begin
            sort_in[k] = sort_ff[k];
         end else if (sort_ge[k-1]) begin
            sort_in[k] = ins_value;
         end else begin
            sort_in[k] = sort_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sort_load) begin
         sort_ff[0] <= signed'(req_tdata);
         for (int k = 1; k < WINDOW; k++) begin
            sort_ff[k] <= SAMPLE_MIN;
         end
      end else if (sort_insert) begin
         sort_ff <= sort_in;
      end
   end

   // Weighted sum in three registered steps; it settles while the sorter holds still
   always_ff @(posedge clock) begin
      part_hi_ff   <= PART_W'(sort_ff[3]) + PART_W'(sort_ff[4]) + PART_W'(sort_ff[5]);
      part_lo_ff   <= PART_W'(sort_ff[6]) + PART_W'(sort_ff[7]) + PART_W'(sort_ff[8]);
      pair_near_ff <= PAIR_W'(sort_ff[1]) + PAIR_W'(sort_ff[10]);
      pair_far_ff  <= PAIR_W'(sort_ff[2]) + PAIR_W'(sort_ff[9]);
      mid_ff       <= MID_W'(part_hi_ff) + MID_W'(part_lo_ff);
      edge_ff      <= (MID_W'(pair_near_ff) <<< 1) + MID_W'(pair_far_ff);
      acc_ff       <= (ACC_W'(mid_ff) <<< 2) + ACC_W'(mid_ff) + ACC_W'(edge_ff);
   end

   // Magnitude over four, then division by nine through the reciprocal
   assign acc_abs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;

   always_ff @(posedge clock) begin
      mag_ff     <= acc_abs[ACC_W-2:2];
      neg_abs_ff <= acc_ff[ACC_W-1];
      prod_ff    <= PROD_W'(mag_ff) * PROD_W'(RECIP_NINE);
      neg_mul_ff <= neg_abs_ff;
   end

   // Quotient and sign restored, truncating toward zero
   assign quot   = prod_ff[RECIP_SHIFT +: SAMPLE_W];
   assign result = neg_mul_ff ? (~quot + 1'b1) : quot;

   // Output register, freed when the receiver takes the transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sim/swtm_checker.sv
// Checker for the sorted-window trimmed mean filter: predicts and compares results.
// Watches both stream channels of the block; depends on swtm_pkg for the window geometry.
`timescale 1ns / 1ps

module swtm_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [swtm_pkg::SAMPLE_W-1:0] req_tdata,    // [23:0] sample
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [swtm_pkg::SAMPLE_W-1:0] rsp_tdata,    // [23:0] filtered
   output int                            mismatch_count,
   output int                            means_due,
   output int                            means_seen
);

   import swtm_pkg::*;

   // Weights scaled by five so that the total weight of 7.2 becomes 36.
   localparam longint FULL_WEIGHT  = 5;
   localparam longint NEAR_WEIGHT  = 2;
   localparam longint TOTAL_WEIGHT = 36;

   logic signed [SAMPLE_W-1:0] recent_samples [WINDOW];
   logic [SAMPLE_W-1:0]        pending_means [$];

   initial begin
      mismatch_count = 0;
      means_due      = 0;
      means_seen     = 0;
   end

   // Ranks the current window in descending order and forms the weighted trimmed mean.
   function automatic logic [SAMPLE_W-1:0] weighted_trimmed_mean();
      longint ranked [WINDOW];
      longint held;
      longint weighted_sum;
      longint mean;
      int     i;
      int     j;
      for (i = 0; i < WINDOW; i++) begin
         ranked[i] = longint'(recent_samples[i]);
      end
      for (i = 1; i < WINDOW; i++) begin
         held = ranked[i];
         j    = i - 1;
         while (j >= 0 && ranked[j] < held) begin
            ranked[j + 1] = ranked[j];
            j--;
         end
         ranked[j + 1] = held;
      end
      // The largest and smallest ranks are dropped altogether.
      weighted_sum = 0;
      for (i = 3; i <= WINDOW - 4; i++) begin
         weighted_sum += FULL_WEIGHT * ranked[i];
      end
      weighted_sum += NEAR_WEIGHT * (ranked[1] + ranked[WINDOW - 2]);
      weighted_sum += ranked[2] + ranked[WINDOW - 3];
      // Integer division in SystemVerilog truncates toward zero, as required.
      mean = weighted_sum / TOTAL_WEIGHT;
      return mean[SAMPLE_W-1:0];
   endfunction

   // Results are checked before the new sample is taken, since a result
   // always belongs to an earlier transaction.
   always @(posedge clock) begin
      int k;
      if (reset) begin
         for (k = 0; k < WINDOW; k++) begin
            recent_samples[k] = '0;
         end
         pending_means.delete();
         means_due  <= 0;
         means_seen <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_means.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %0d",
                        $time, $signed(rsp_tdata));
               mismatch_count++;
            end else if (rsp_tdata !== pending_means[0]) begin
               $display("%0t: filtered mismatch: expected %0d, actual %0d",
                        $time, $signed(pending_means[0]), $signed(rsp_tdata));
               mismatch_count++;
               void'(pending_means.pop_front());
            end else begin
               void'(pending_means.pop_front());
            end
            means_seen <= means_seen + 1;
         end
         if (req_tvalid && req_tready) begin
            for (k = WINDOW - 1; k > 0; k--) begin
               recent_samples[k] = recent_samples[k - 1];
            end
            recent_samples[0] = req_tdata;
            pending_means.push_back(weighted_trimmed_mean());
         end
         means_due <= pending_means.size();
      end
   end

endmodule

FILE: sim/tb.sv
// Testbench top for the sorted-window trimmed mean filter: clock, reset, stimulus and verdict.
// Depends on swtm_pkg, the block sorted_window_trimmed_mean and the checker swtm_checker.
`timescale 1ns / 1ps

module tb;
   import swtm_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int ITEM_TARGET  = 1300;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 300;
   localparam int DRAIN_CYCLES = 40;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] MINUS_ONE  = '1;
   localparam logic [SAMPLE_W-1:0] PLUS_ONE   = SAMPLE_W'(1);

   typedef enum int {
      PAT_RANDOM,
      PAT_LOAD_CELL,
      PAT_EXTREME,
      PAT_CONSTANT
   } pattern_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;

   int mismatch_count;
   int means_due;
   int means_seen;
   int idle_cycles = 0;
   bit burst       = 1'b0;
   bit held_off    = 1'b0;

   sorted_window_trimmed_mean i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   swtm_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .means_due      (means_due),
      .means_seen     (means_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Gap before a transaction: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 60) begin
         return 0;
      end
      if (roll < 96) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(20, 80);
   endfunction

   // One of the values at the edges of the sample range.
   function automatic logic [SAMPLE_W-1:0] pick_extreme();
      case ($urandom_range(0, 5))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return MINUS_ONE;
         4:       return PLUS_ONE;
         default: return SAMPLE_MAX - PLUS_ONE;
      endcase
   endfunction

   // Offers one sample and returns at the edge where it is accepted.
   task automatic send_reading(input logic [SAMPLE_W-1:0] reading);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= reading;
      do @(posedge clock); while (!req_tready);
   endtask

   // Sample stream: directed start-up and edge cases, then random runs.
   initial begin
      pattern_type         pattern;
      logic [SAMPLE_W-1:0] reading;
      logic [SAMPLE_W-1:0] held_value;
      int                  base_level;
      int                  run_len;
      int                  sent;
      int                  n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Start-up with reset zeros still in the window, then a window full of
      // the largest value and a few of the smallest.
      send_reading(SAMPLE_W'(100));
      send_reading(-SAMPLE_W'(100));
      send_reading(SAMPLE_MAX);
      send_reading(SAMPLE_MIN);
      send_reading(PLUS_ONE);
      send_reading(MINUS_ONE);
      send_reading(24'h555555);
      send_reading(24'hAAAAAA);
      repeat (12) send_reading(SAMPLE_MAX);
      repeat (5) send_reading(SAMPLE_MIN);

      sent = 25;
      while (sent < ITEM_TARGET) begin
         pattern    = pattern_type'($urandom_range(0, 3));
         burst      = ($urandom_range(0, 4) == 0);
         run_len    = $urandom_range(10, 30);
         base_level = $urandom_range(0, 2 * 1000000) - 1000000;
         held_value = ($urandom_range(0, 1) == 0) ? pick_extreme() : SAMPLE_W'($urandom);
         if (pattern == PAT_CONSTANT) begin
            run_len = $urandom_range(12, 16);
         end
         for (n = 0; n < run_len; n++) begin
            case (pattern)
               PAT_RANDOM: begin
                  reading = SAMPLE_W'($urandom);
               end
               PAT_LOAD_CELL: begin
                  // Slowly drifting reading with small noise and the odd spike.
                  base_level += $urandom_range(0, 20) - 10;
                  reading = SAMPLE_W'(base_level + $urandom_range(0, 63) - 32);
                  if ($urandom_range(0, 39) == 0) begin
                     reading = pick_extreme();
                  end
               end
               PAT_EXTREME: begin
                  reading = pick_extreme();
               end
               default: begin
                  reading = held_value;
               end
            endcase
            send_reading(reading);
            sent++;
         end
      end
      burst = 1'b0;
      req_tvalid <= 1'b0;

      // Drain every expected result, then allow for the block's latency.
      @(posedge clock);
      while (means_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Result receiver: random stalls, plus one long hold-off while samples are still being offered.
   initial begin
      int stall_len;
      repeat (9) @(posedge clock);
      forever begin
         if (!held_off && means_seen >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            stall_len = HOLD_CYCLES;
         end else if (burst || $urandom_range(0, 99) < 60) begin
            rsp_tready <= 1'b1;
            stall_len = $urandom_range(1, 8);
         end else begin
            rsp_tready <= 1'b0;
            stall_len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 4);
         end
         repeat (stall_len) @(posedge clock);
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
